[rtl/rle_pkg.sv]
// Shared types and constants of the byte run-length encoder.
package rle_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned BUDGET_W    = 16;
  localparam int unsigned MAX_RUN_DEF = 255;
  localparam int unsigned BUDGET_RST  = 65535;
  localparam int unsigned OUTQ_DEPTH  = 4;

  localparam logic [1:0]  ADDR_BUDGET = 2'd0;

  typedef struct packed {
    logic [BYTE_W-1:0] run_count;
    logic [BYTE_W-1:0] run_value;
    logic              last_pair;
    logic              budget_full;
  } pair_t;

  typedef struct packed {
    logic [1:0] num;
    pair_t      first;
    pair_t      second;
  } push_t;

endpackage

[rtl/byte_run_length_encoder.sv]
// Top level of the byte run-length encoder with an output budget.
//
// The input stream carries one raw byte per transaction in in_tdata, and
// in_tlast marks the final byte of a block. Each run of equal bytes, cut at
// MAX_RUN bytes, leaves as (count, value) pairs: out_tdata holds the count
// in the low byte and the value in the high byte, out_tlast marks the last
// pair of a block and out_tuser flags that the output budget stopped the
// block early. The budget register at address 0 of the configuration port
// limits the encoded bytes per block; the user must write it while the
// block is idle, as the block does not enforce it. A byte is handled in
// the cycle it is accepted; its pairs, at most two, are registered in the
// result queue and leave it one per cycle while the receiver takes them.
// One byte is taken every cycle while the four-entry queue has room for two
// pairs; a stalled receiver or two-pair bytes fill it; in_tready goes low.
// Reset clears the run state and the queue and sets the budget to 65535.
module byte_run_length_encoder #(
  parameter int unsigned MAX_RUN = rle_pkg::MAX_RUN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] run_count, [15:8] run_value
  output logic        out_tlast,
  output logic [0:0]  out_tuser,  // [0] budget_full
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [rle_pkg::BUDGET_W-1:0] output_budget_r, output_budget_nxt;
  logic                         cfg_write, accept, room;
  rle_pkg::push_t               push;
  rle_pkg::pair_t               out_pair;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == rle_pkg::ADDR_BUDGET);
  assign output_budget_nxt = cfg_write ? cfg_pwdata[rle_pkg::BUDGET_W-1:0]
                                       : output_budget_r;
  assign cfg_prdata = {16'd0, output_budget_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      output_budget_r <= rle_pkg::BUDGET_W'(rle_pkg::BUDGET_RST);
    end else begin
      output_budget_r <= output_budget_nxt;
    end
  end

  assign in_tready = room;
  assign accept    = in_tvalid && in_tready;

  rle_core #(
    .MAX_RUN(MAX_RUN)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_tdata),
    .end_of_block (in_tlast),
    .output_budget(output_budget_r),
    .push         (push)
  );

  rle_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_pair (out_pair)
  );

  assign out_tdata = {out_pair.run_value, out_pair.run_count};
  assign out_tlast = out_pair.last_pair;
  assign out_tuser = out_pair.budget_full;

  a_full_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tlast)
    else $error("Budget stop flagged on a pair that is not last.");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:0] != 8'd0))
    else $error("Pair with zero run length.");

  a_no_output_small_budget: assert property (@(posedge clk) disable iff (!rst_n)
    (output_budget_r < rle_pkg::BUDGET_W'(3)) |-> (push.num == 2'd0))
    else $error("Pair produced with a budget too small for any run.");

endmodule

[rtl/rle_core.sv]
// Run tracking, budget check and pair generation for one accepted byte.
module rle_core #(
  parameter int unsigned MAX_RUN = rle_pkg::MAX_RUN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [rle_pkg::BYTE_W-1:0]    data_byte,
  input  logic                          end_of_block,
  input  logic [rle_pkg::BUDGET_W-1:0]  output_budget,
  output rle_pkg::push_t                push
);

  localparam logic [rle_pkg::BYTE_W-1:0] MaxRun = rle_pkg::BYTE_W'(MAX_RUN);

  logic [rle_pkg::BYTE_W-1:0]   held_value_r, held_value_nxt;
  logic [rle_pkg::BYTE_W-1:0]   held_count_r, held_count_nxt;
  logic [rle_pkg::BUDGET_W-1:0] bytes_emitted_r, bytes_emitted_nxt;
  logic                         block_stopped_r, block_stopped_nxt;

  logic                         extend, pair1, pair2, stop1, may_start_a, full_b;
  logic [rle_pkg::BUDGET_W-1:0] emitted_a, emitted_b;
  logic [rle_pkg::BYTE_W-1:0]   count1, value1;
  rle_pkg::pair_t               pair1_d, pair2_d;

  always_comb begin
    extend      = (held_count_r != '0) && (data_byte == held_value_r) &&
                  (held_count_r < MaxRun);
    pair1       = !block_stopped_r && !extend && (held_count_r != '0);
    emitted_a   = pair1 ? bytes_emitted_r + rle_pkg::BUDGET_W'(2) : bytes_emitted_r;
    may_start_a = ({1'b0, emitted_a} + 17'd2) < {1'b0, output_budget};
    stop1       = !block_stopped_r && !extend && !may_start_a;

    if (block_stopped_r) begin
      count1 = held_count_r;
      value1 = held_value_r;
    end else if (extend) begin
      count1 = held_count_r + 8'd1;
      value1 = held_value_r;
    end else if (!stop1) begin
      count1 = 8'd1;
      value1 = data_byte;
    end else begin
      count1 = '0;
      value1 = held_value_r;
    end

    pair2     = !block_stopped_r && !stop1 && (count1 != '0) &&
                ((count1 >= MaxRun) || end_of_block);
    emitted_b = emitted_a + rle_pkg::BUDGET_W'(2);
    full_b    = !(({1'b0, emitted_b} + 17'd2) < {1'b0, output_budget});

    pair1_d.run_count   = held_count_r;
    pair1_d.run_value   = held_value_r;
    pair1_d.last_pair   = !may_start_a;
    pair1_d.budget_full = !may_start_a;

    pair2_d.run_count   = count1;
    pair2_d.run_value   = value1;
    pair2_d.last_pair   = full_b || end_of_block;
    pair2_d.budget_full = full_b && !end_of_block;

    push.num    = accept ? ({1'b0, pair1} + {1'b0, pair2}) : 2'd0;
    push.first  = pair1 ? pair1_d : pair2_d;
    push.second = pair2_d;

    held_value_nxt    = held_value_r;
    held_count_nxt    = held_count_r;
    bytes_emitted_nxt = bytes_emitted_r;
    block_stopped_nxt = block_stopped_r;
    if (accept) begin
      if (end_of_block) begin
        held_value_nxt    = '0;
        held_count_nxt    = '0;
        bytes_emitted_nxt = '0;
        block_stopped_nxt = 1'b0;
      end else begin
        held_value_nxt    = value1;
        held_count_nxt    = pair2 ? '0 : count1;
        bytes_emitted_nxt = pair2 ? emitted_b : emitted_a;
        block_stopped_nxt = block_stopped_r || stop1 || (pair2 && full_b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_value_r    <= '0;
      held_count_r    <= '0;
      bytes_emitted_r <= '0;
      block_stopped_r <= 1'b0;
    end else begin
      held_value_r    <= held_value_nxt;
      held_count_r    <= held_count_nxt;
      bytes_emitted_r <= bytes_emitted_nxt;
      block_stopped_r <= block_stopped_nxt;
    end
  end

  a_stopped_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    block_stopped_r |-> (held_count_r == '0))
    else $error("Run held while the block is stopped.");

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_count_r <= MaxRun)
    else $error("Held run exceeds the maximum run length.");

  a_emitted_even: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_emitted_r[0] == 1'b0)
    else $error("Emitted byte count is odd.");

endmodule

[rtl/rle_outq.sv]
// Result queue taking up to two pairs per cycle, releasing one on ready.
module rle_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  rle_pkg::push_t push,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output rle_pkg::pair_t out_pair
);

  localparam int unsigned PtrW = $clog2(rle_pkg::OUTQ_DEPTH);
  localparam int unsigned CntW = PtrW + 1;

  rle_pkg::pair_t      mem_r [rle_pkg::OUTQ_DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [CntW-1:0]     count_r, count_nxt;
  logic                pop;

  always_comb begin
    pop        = out_valid && out_ready;
    wr_ptr_p1  = wr_ptr_r + PtrW'(1);
    wr_ptr_nxt = wr_ptr_r + PtrW'(push.num);
    rd_ptr_nxt = rd_ptr_r + PtrW'(pop);
    count_nxt  = count_r + CntW'(push.num) - CntW'(pop);
  end

  assign room      = count_r <= CntW'(rle_pkg::OUTQ_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_pair  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.num == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(rle_pkg::OUTQ_DEPTH))
    else $error("Result queue overflow.");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("Empty queue with mismatched pointers.");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.num != 2'd0) |-> room)
    else $error("Pair pushed without room in the queue.");

endmodule

[sim/tb.sv]
// Self-checking testbench for the byte run-length encoder with an output budget.
module tb;

  localparam int unsigned MAX_RUN_LEN  = rle_pkg::MAX_RUN_DEF;
  localparam logic [1:0]  BUDGET_ADDR  = rle_pkg::ADDR_BUDGET;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          LIMIT_CYCLES = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;   // [7:0] data_byte
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [7:0] run_count, [15:8] run_value
  logic        out_tlast;
  logic [0:0]  out_tuser;         // [0] budget_full
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = 2'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  byte_run_length_encoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rle_pkg::pair_t pending_pairs[$];
  logic [15:0]   budget = 16'(rle_pkg::BUDGET_RST);
  logic [7:0]    run_val = 8'd0;
  logic [7:0]    run_len = 8'd0;
  logic [15:0]   emitted = 16'd0;
  bit            stopped = 1'b0;
  int            errors = 0;
  int            cycles = 0;
  bit            tx_idle = 1'b1;
  bit            rx_idle = 1'b1;
  bit            hold_req = 1'b0;
  int            stall_left = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic bit may_open();
    return int'(emitted) < int'(budget) - 2;
  endfunction

  task automatic emit_pair(input bit eob, output bit full);
    rle_pkg::pair_t p;
    p.run_count = run_len;
    p.run_value = run_val;
    emitted = emitted + 16'd2;
    run_len = 8'd0;
    full = !may_open();
    p.last_pair = full || eob;
    p.budget_full = full && !eob;
    pending_pairs.push_back(p);
  endtask

  task automatic encode_byte(input logic [7:0] b, input bit eob);
    bit full;
    if (!stopped) begin
      if (run_len != 0 && b == run_val && run_len < MAX_RUN_LEN) begin
        run_len++;
      end else begin
        if (run_len != 0) begin
          emit_pair(1'b0, full);
          if (full) stopped = 1'b1;
        end
        if (!stopped) begin
          if (may_open()) begin
            run_val = b;
            run_len = 8'd1;
          end else begin
            stopped = 1'b1;
          end
        end
      end
      if (!stopped && run_len != 0 && (run_len >= MAX_RUN_LEN || eob)) begin
        emit_pair(eob, full);
        if (full) stopped = 1'b1;
      end
    end
    if (eob) begin
      run_val = 8'd0;
      run_len = 8'd0;
      emitted = 16'd0;
      stopped = 1'b0;
    end
  endtask

  always @(posedge clk) begin : check_pairs
    rle_pkg::pair_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected pair: count %0d value 0x%02h", out_tdata[7:0], out_tdata[15:8]);
        errors++;
      end else begin
        want = pending_pairs.pop_front();
        if (out_tdata[7:0] !== want.run_count) begin
          $error("run_count: expected %0d, got %0d", want.run_count, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[15:8] !== want.run_value) begin
          $error("run_value: expected 0x%02h, got 0x%02h", want.run_value, out_tdata[15:8]);
          errors++;
        end
        if (out_tlast !== want.last_pair) begin
          $error("last_pair: expected %0b, got %0b", want.last_pair, out_tlast);
          errors++;
        end
        if (out_tuser[0] !== want.budget_full) begin
          $error("budget_full: expected %0b, got %0b", want.budget_full, out_tuser[0]);
          errors++;
        end
      end
    end
  end

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && rx_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit eob);
    int gap;
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eob;
    do @(posedge clk); while (!in_tready);
    encode_byte(b, eob);
  endtask

  task automatic send_run(input logic [7:0] b, input int count, input bit eob);
    for (int i = 0; i < count; i++) send_byte(b, eob && i == count - 1);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_budget(input logic [15:0] val);
    drain();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= BUDGET_ADDR;
    cfg_pwdata  <= {16'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    budget = val;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {16'd0, budget}) begin
      $error("output_budget: expected %0d, got %0d", budget, cfg_prdata);
      errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte(input logic [7:0] prev);
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return prev;
      4:          return 8'h00;
      5:          return 8'hFF;
      default:    return 8'($urandom);
    endcase
  endfunction

  task automatic random_blocks(input int n_items, input int max_len, input bit allow_long);
    int         sent;
    int         len;
    bit         long_run;
    logic [7:0] b;
    sent = 0;
    b = 8'($urandom);
    while (sent < n_items) begin
      long_run = allow_long && $urandom_range(0, 39) == 0;
      len = long_run ? $urandom_range(250, 520) : $urandom_range(1, max_len);
      if (long_run) b = 8'($urandom);
      for (int i = 0; i < len; i++) begin
        if (!long_run) b = pick_byte(b);
        send_byte(b, i == len - 1);
      end
      sent += len;
    end
  endtask

  task automatic test_basic_runs();
    send_byte(8'h00, 1'b1);
    send_run(8'hFF, 3, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b1);
    send_run(8'hA5, 2, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_run(8'h01, 2, 1'b1);
    drain();
  endtask

  task automatic test_max_run();
    send_run(8'h3C, MAX_RUN_LEN, 1'b0);
    send_run(8'h3C, 2, 1'b0);
    send_byte(8'hC3, 1'b1);
    drain();
  endtask

  task automatic test_budget_limits();
    write_budget(16'd2);
    send_run(8'h11, 2, 1'b0);
    send_byte(8'h22, 1'b1);
    write_budget(16'd3);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b1);
    write_budget(16'd4);
    send_run(8'h55, 2, 1'b1);
    write_budget(16'd6);
    send_run(8'hAA, 2, 1'b0);
    send_byte(8'hBB, 1'b0);
    send_byte(8'hCC, 1'b0);
    send_byte(8'hDD, 1'b0);
    send_byte(8'hEE, 1'b1);
    drain();
  endtask

  task automatic test_budget_midblock();
    write_budget(16'd65535);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    write_budget(16'd4);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b1);
    drain();
  endtask

  task automatic test_random_traffic();
    write_budget(16'd65535);
    random_blocks(300, 40, 1'b1);
    write_budget(16'($urandom_range(3, 12)));
    random_blocks(200, 30, 1'b0);
    write_budget(16'd2);
    random_blocks(60, 20, 1'b0);
    write_budget(16'($urandom_range(13, 300)));
    random_blocks(200, 60, 1'b1);
    write_budget(16'd65534);
    random_blocks(100, 40, 1'b0);
    write_budget(16'($urandom_range(3, 65535)));
    random_blocks(100, 40, 1'b0);
    drain();
  endtask

  task automatic test_backpressure();
    write_budget(16'd65535);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 60; i++) send_byte(8'(i * 37), i % 10 == 9);
    drain();
  endtask

  task automatic test_streaming();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    random_blocks(200, 40, 1'b0);
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_runs();
    test_max_run();
    test_budget_limits();
    test_budget_midblock();
    test_random_traffic();
    test_backpressure();
    test_streaming();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
